// File: sv/spn_pkg.sv
// ----------------------------------------------------------------------------
// spn_pkg
// shared constants, operation codes and table access types
// ----------------------------------------------------------------------------
package spn_pkg;
    localparam int BLOCK_BITS   = 64;
    localparam int MAX_ROUNDS   = 32;
    localparam int SBOX_ENTRIES = 256;
    localparam int KEY_AW       = $clog2(MAX_ROUNDS + 1);
    localparam int SBOX_AW      = $clog2(SBOX_ENTRIES);
    localparam int COL_AW       = $clog2(BLOCK_BITS);
    localparam int RND_W        = $clog2(MAX_ROUNDS + 1);

    localparam logic [2:0] OP_ENC      = 3'd0;
    localparam logic [2:0] OP_DEC      = 3'd1;
    localparam logic [2:0] OP_LD_KEY   = 3'd2;
    localparam logic [2:0] OP_LD_SBOX  = 3'd3;
    localparam logic [2:0] OP_LD_ISBOX = 3'd4;
    localparam logic [2:0] OP_LD_COL   = 3'd5;
    localparam logic [2:0] OP_LD_ICOL  = 3'd6;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_ROUNDS = 2'd2;

    typedef struct packed {
        logic                  key_we;
        logic                  sf_we;
        logic                  si_we;
        logic                  cf_we;
        logic                  ci_we;
        logic [7:0]            idx;
        logic [BLOCK_BITS-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic [KEY_AW-1:0]  key_addr;
        logic [SBOX_AW-1:0] sbox_addr;
        logic [COL_AW-1:0]  col_addr;
        logic               inv;
    } t_tbl_rd;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] key_q;
        logic [7:0]            sbox_q;
        logic [BLOCK_BITS-1:0] col_q;
    } t_tbl_q;

    typedef struct packed {
        logic [3:0]       width;
        logic [4:0]       count;
        logic [RND_W-1:0] rounds;
    } t_cfg;
endpackage

// File: sv/spn_block_cipher_engine.sv
// ----------------------------------------------------------------------------
// blocks are processed one at a time, R rounds of N chunks per block;
// the round time is set by the single read port of the s-box memory (one
// chunk a cycle) and of the column memory (one column a cycle)
// each table load is written from a single input beat; synchronous
// active-low reset clears control state and restores the register
// defaults, tables stay unwritten
// ----------------------------------------------------------------------------
module spn_block_cipher_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [2:0]                     i_operation,
    input  logic [7:0]                     i_entry_index,
    input  logic [spn_pkg::BLOCK_BITS-1:0] i_data_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [spn_pkg::BLOCK_BITS-1:0] o_block_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import spn_pkg::*;

    t_cfg    cfg;
    t_tbl_wr tbl_wr;
    t_tbl_rd tbl_rd;
    t_tbl_q  tbl_q;

    spn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spn_tables u_tables (
        .i_clk (i_clk),
        .i_wr  (tbl_wr),
        .i_rd  (tbl_rd),
        .o_q   (tbl_q)
    );

    spn_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_block_out   (o_block_out),
        .o_wr          (tbl_wr),
        .o_rd          (tbl_rd),
        .i_q           (tbl_q)
    );
endmodule

// File: sv/spn_cfg.sv
// ----------------------------------------------------------------------------
// spn_cfg
// apb register file, hands out range-limited settings
// ----------------------------------------------------------------------------
module spn_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output spn_pkg::t_cfg o_cfg
);
    import spn_pkg::*;

    logic [3:0] r_width;
    logic [4:0] r_count;
    logic [5:0] r_rounds;
    logic       wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 4'd4;
            r_count  <= 5'd16;
            r_rounds <= 6'd31;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[3:0];
                REG_COUNT:  r_count  <= pwdata[4:0];
                REG_ROUNDS: r_rounds <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_WIDTH:  prdata = {28'd0, r_width};
                REG_COUNT:  prdata = {27'd0, r_count};
                REG_ROUNDS: prdata = {26'd0, r_rounds};
                default:    prdata = '0;
            endcase
        end
    end

    always_comb begin
        o_cfg.width = (r_width < 4'd4) ? 4'd4 : (r_width > 4'd8) ? 4'd8 : r_width;
        o_cfg.count = (r_count == 5'd0) ? 5'd1 : (r_count > 5'd16) ? 5'd16 : r_count;
        if (r_rounds == 6'd0)
            o_cfg.rounds = RND_W'(1);
        else if (r_rounds > 6'(MAX_ROUNDS))
            o_cfg.rounds = RND_W'(MAX_ROUNDS);
        else
            o_cfg.rounds = RND_W'(r_rounds);
    end
endmodule

// File: sv/spn_tables.sv
// ----------------------------------------------------------------------------
// spn_tables
// round key, s-box and linear layer column memories, registered reads
// ----------------------------------------------------------------------------
module spn_tables (
    input  logic             i_clk,
    input  spn_pkg::t_tbl_wr i_wr,
    input  spn_pkg::t_tbl_rd i_rd,
    output spn_pkg::t_tbl_q  o_q
);
    import spn_pkg::*;

    logic [BLOCK_BITS-1:0] mem_key [MAX_ROUNDS+1];
    logic [7:0]            mem_sf  [SBOX_ENTRIES];
    logic [7:0]            mem_si  [SBOX_ENTRIES];
    logic [BLOCK_BITS-1:0] mem_cf  [BLOCK_BITS];
    logic [BLOCK_BITS-1:0] mem_ci  [BLOCK_BITS];

    logic [BLOCK_BITS-1:0] r_key_q;
    logic [7:0]            r_sf_q;
    logic [7:0]            r_si_q;
    logic [BLOCK_BITS-1:0] r_cf_q;
    logic [BLOCK_BITS-1:0] r_ci_q;
    logic                  r_inv;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) mem_key[i_wr.idx[KEY_AW-1:0]] <= i_wr.data;
        if (i_wr.sf_we)  mem_sf[i_wr.idx[SBOX_AW-1:0]] <= i_wr.data[7:0];
        if (i_wr.si_we)  mem_si[i_wr.idx[SBOX_AW-1:0]] <= i_wr.data[7:0];
        if (i_wr.cf_we)  mem_cf[i_wr.idx[COL_AW-1:0]]  <= i_wr.data;
        if (i_wr.ci_we)  mem_ci[i_wr.idx[COL_AW-1:0]]  <= i_wr.data;
        r_key_q <= mem_key[i_rd.key_addr];
        r_sf_q  <= mem_sf[i_rd.sbox_addr];
        r_si_q  <= mem_si[i_rd.sbox_addr];
        r_cf_q  <= mem_cf[i_rd.col_addr];
        r_ci_q  <= mem_ci[i_rd.col_addr];
        r_inv   <= i_rd.inv;
    end

    assign o_q.key_q  = r_key_q;
    assign o_q.sbox_q = r_inv ? r_si_q : r_sf_q;
    assign o_q.col_q  = r_inv ? r_ci_q : r_cf_q;
endmodule

// File: sv/spn_round.sv
// ----------------------------------------------------------------------------
// spn_round
// round sequencer: key add, chunk-serial substitution, column-serial mixing
// ----------------------------------------------------------------------------
module spn_round (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spn_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [2:0]                     i_operation,
    input  logic [7:0]                     i_entry_index,
    input  logic [spn_pkg::BLOCK_BITS-1:0] i_data_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [spn_pkg::BLOCK_BITS-1:0] o_block_out,
    output spn_pkg::t_tbl_wr               o_wr,
    output spn_pkg::t_tbl_rd               o_rd,
    input  spn_pkg::t_tbl_q                i_q
);
    import spn_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KEY   = 6'b000010,
        S_KEYW  = 6'b000100,
        S_SUB   = 6'b001000,
        S_MIX   = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_dec, n_dec;
    logic                  r_final, n_final;
    logic [RND_W-1:0]      r_round, n_round;
    logic [KEY_AW-1:0]     r_kaddr, n_kaddr;
    logic [6:0]            r_cnt, n_cnt;
    logic [BLOCK_BITS-1:0] r_s, n_s;
    logic [BLOCK_BITS-1:0] r_acc, n_acc;
    logic [7:0]            r_pos, n_pos;
    logic                  r_ck_ok, n_ck_ok;
    logic                  r_ovalid, n_ovalid;
    logic [BLOCK_BITS-1:0] r_out, n_out;

    logic                  acc_in;
    logic [7:0]            mask;
    logic [7:0]            pos_i;
    logic [BLOCK_BITS-1:0] shifted;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_block_out = r_out;
    assign acc_in      = i_valid && o_ready;
    assign mask        = 8'((9'd1 << i_cfg.width) - 9'd1);
    assign pos_i       = {3'd0, r_cnt[4:0]} * {4'd0, i_cfg.width};
    assign shifted     = r_s >> pos_i[5:0];

    always_comb begin
        o_wr.key_we = acc_in && i_operation == OP_LD_KEY
                      && {1'b0, i_entry_index} <= 9'(MAX_ROUNDS);
        o_wr.sf_we  = acc_in && i_operation == OP_LD_SBOX
                      && {1'b0, i_entry_index} < 9'(SBOX_ENTRIES);
        o_wr.si_we  = acc_in && i_operation == OP_LD_ISBOX
                      && {1'b0, i_entry_index} < 9'(SBOX_ENTRIES);
        o_wr.cf_we  = acc_in && i_operation == OP_LD_COL
                      && {1'b0, i_entry_index} < 9'(BLOCK_BITS);
        o_wr.ci_we  = acc_in && i_operation == OP_LD_ICOL
                      && {1'b0, i_entry_index} < 9'(BLOCK_BITS);
        o_wr.idx    = i_entry_index;
        o_wr.data   = i_data_word;
        o_rd.key_addr  = r_kaddr;
        o_rd.sbox_addr = SBOX_AW'(shifted[7:0] & mask);
        o_rd.col_addr  = r_cnt[COL_AW-1:0];
        o_rd.inv       = r_dec;
    end

    always_comb begin
        n_state  = r_state;
        n_dec    = r_dec;
        n_final  = r_final;
        n_round  = r_round;
        n_kaddr  = r_kaddr;
        n_cnt    = r_cnt;
        n_s      = r_s;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_ck_ok  = r_ck_ok;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc_in && (i_operation == OP_ENC || i_operation == OP_DEC)) begin
                    n_s     = i_data_word;
                    n_dec   = (i_operation == OP_DEC);
                    n_final = 1'b0;
                    n_state = S_KEY;
                    if (i_operation == OP_DEC) begin
                        n_round = i_cfg.rounds;
                        n_kaddr = KEY_AW'(i_cfg.rounds);
                    end else begin
                        n_round = '0;
                        n_kaddr = '0;
                    end
                end
            end
            S_KEY: n_state = S_KEYW;
            S_KEYW: begin
                n_s   = r_s ^ i_q.key_q;
                n_cnt = '0;
                n_acc = '0;
                if (r_dec) n_state = (r_round == '0) ? S_FLUSH : S_MIX;
                else       n_state = r_final ? S_FLUSH : S_SUB;
            end
            S_SUB: begin
                if (r_cnt != 7'd0 && r_ck_ok)
                    n_acc = r_acc | (BLOCK_BITS'(i_q.sbox_q & mask) << r_pos[5:0]);
                n_pos   = pos_i;
                n_ck_ok = (pos_i < 8'(BLOCK_BITS));
                n_cnt   = r_cnt + 7'd1;
                if (r_cnt == 7'(i_cfg.count)) begin
                    n_s   = n_acc;
                    n_cnt = '0;
                    n_acc = '0;
                    if (r_dec) begin
                        n_round = r_round - RND_W'(1);
                        n_kaddr = KEY_AW'(r_round - RND_W'(1));
                        n_state = S_KEY;
                    end else begin
                        n_state = S_MIX;
                    end
                end
            end
            S_MIX: begin
                if (r_cnt != 7'd0 && r_s[6'(r_cnt - 7'd1)])
                    n_acc = r_acc ^ i_q.col_q;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(BLOCK_BITS)) begin
                    n_s   = n_acc;
                    n_cnt = '0;
                    n_acc = '0;
                    if (r_dec) begin
                        n_state = S_SUB;
                    end else begin
                        n_round = r_round + RND_W'(1);
                        n_kaddr = KEY_AW'(r_round + RND_W'(1));
                        n_final = (r_round + RND_W'(1) == i_cfg.rounds);
                        n_state = S_KEY;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_out    = r_s;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_round  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_round  <= n_round;
        end
        r_dec   <= n_dec;
        r_final <= n_final;
        r_kaddr <= n_kaddr;
        r_s     <= n_s;
        r_acc   <= n_acc;
        r_pos   <= n_pos;
        r_ck_ok <= n_ck_ok;
        r_out   <= n_out;
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= RND_W'(MAX_ROUNDS))
        else $error("round counter out of range");
    a_mix_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> (r_cnt <= 7'(BLOCK_BITS)))
        else $error("mix counter overrun");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && (i_operation == OP_ENC || i_operation == OP_DEC)) |=> (r_state == S_KEY))
        else $error("crypt beat did not start the key stage");
    a_flush_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && (!r_ovalid || i_ready)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result not presented");
endmodule

// File: tb/tb_spn_block_cipher_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spn_block_cipher_engine
// loads keys, s-boxes and linear-layer columns, then pushes encrypt and
// decrypt beats through the engine under random gaps and back-pressure and
// compares every output block against a behavioural cipher kept in the bench
// ----------------------------------------------------------------------------
module tb_spn_block_cipher_engine;
    import spn_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_operation = OP_ENC;
    logic [7:0]  i_entry_index = '0;
    logic [63:0] i_data_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_block_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    spn_block_cipher_engine DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam logic [2:0] OP_NONE = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic [63:0] key_tbl [0:MAX_ROUNDS];
    logic [7:0]  sbox_fw [0:SBOX_ENTRIES-1];
    logic [7:0]  sbox_iv [0:SBOX_ENTRIES-1];
    logic [63:0] col_fw  [0:63];
    logic [63:0] col_iv  [0:63];
    int unsigned cfg_width = 4, cfg_count = 16, cfg_rounds = 31;

    logic [63:0] expected_blocks[$];
    int unsigned n_errors = 0, n_blocks = 0, n_loads = 0, cycles = 0;
    int unsigned out_wait = 0;
    bit          stall_enable = 1'b1;

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [63:0] subst_layer(bit inv, logic [63:0] s);
        int unsigned w, n, pos;
        logic [63:0] mask, t, ent;
        w = sat(cfg_width, 4, 8);
        n = sat(cfg_count, 1, 16);
        mask = (64'd1 << w) - 1;
        t = '0;
        for (int i = 0; i < n; i++) begin
            pos = w * i;
            if (pos < 64) begin
                ent = inv ? sbox_iv[(s >> pos) & mask & 8'hff]
                          : sbox_fw[(s >> pos) & mask & 8'hff];
                t |= (ent & mask) << pos;
            end
        end
        return t;
    endfunction

    function automatic logic [63:0] linear_layer(bit inv, logic [63:0] s);
        logic [63:0] t;
        t = '0;
        for (int i = 0; i < 64; i++)
            if (s[i]) t ^= inv ? col_iv[i] : col_fw[i];
        return t;
    endfunction

    function automatic logic [63:0] cipher_block(bit dec, logic [63:0] s);
        int unsigned rn;
        rn = sat(cfg_rounds, 1, MAX_ROUNDS);
        if (!dec) begin
            for (int r = 0; r < rn; r++)
                s = linear_layer(0, subst_layer(0, s ^ key_tbl[r]));
            return s ^ key_tbl[rn];
        end
        s ^= key_tbl[rn];
        for (int r = rn; r > 0; r--)
            s = subst_layer(1, linear_layer(1, s)) ^ key_tbl[r-1];
        return s;
    endfunction

    // model the beat, queue result
    task automatic cipher_beat(logic [2:0] op, logic [7:0] idx, logic [63:0] d);
        case (op)
            OP_ENC, OP_DEC: begin
                expected_blocks.push_back(cipher_block(op == OP_DEC, d));
                n_blocks++;
            end
            OP_LD_KEY:   if (idx <= MAX_ROUNDS) key_tbl[idx] = d;
            OP_LD_SBOX:  sbox_fw[idx] = d[7:0];
            OP_LD_ISBOX: sbox_iv[idx] = d[7:0];
            OP_LD_COL:   if (idx < 64) col_fw[idx] = d;
            OP_LD_ICOL:  if (idx < 64) col_iv[idx] = d;
            default: ;
        endcase
        if (op inside {OP_LD_KEY, OP_LD_SBOX, OP_LD_ISBOX, OP_LD_COL, OP_LD_ICOL}) n_loads++;
    endtask

    task automatic send_beat(logic [2:0] op, logic [7:0] idx, logic [63:0] d);
        int unsigned gap;
        gap = stall_enable ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_entry_index <= idx;
        i_data_word <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        cipher_beat(op, idx, d);
        @(negedge i_clk);
    endtask

    // per-beat back-pressure on the result side
    always @(negedge i_clk) begin
        if (!o_valid) begin
            out_wait = stall_enable ? $urandom_range(0, 14) : 0;
            i_ready <= (out_wait == 0);
        end else if (out_wait != 0) begin
            out_wait--;
            i_ready <= (out_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[spn_block_cipher_engine] ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("block_out: unexpected beat, actual %h", o_block_out);
                n_errors++;
            end else begin
                if (o_block_out !== expected_blocks[0]) begin
                    $error("block_out: expected %h actual %h", expected_blocks[0], o_block_out);
                    n_errors++;
                end
                void'(expected_blocks.pop_front());
            end
        end
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] reg_id, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {reg_id, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_id)
            REG_WIDTH:  cfg_width = v & 32'hf;
            REG_COUNT:  cfg_count = v & 32'h1f;
            default:    cfg_rounds = v & 32'h3f;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned n, int unsigned r);
        drain();
        apb_write(REG_WIDTH, w);
        apb_write(REG_COUNT, n);
        apb_write(REG_ROUNDS, r);
    endtask

    // fill every table entry that a block can touch
    task automatic test_load_tables();
        for (int i = 0; i <= MAX_ROUNDS; i++) send_beat(OP_LD_KEY, 8'(i), {$urandom, $urandom});
        for (int i = 0; i < SBOX_ENTRIES; i++) begin
            send_beat(OP_LD_SBOX, 8'(i), {$urandom, $urandom});
            send_beat(OP_LD_ISBOX, 8'(i), {$urandom, $urandom});
        end
        for (int i = 0; i < 64; i++) begin
            send_beat(OP_LD_COL, 8'(i), {$urandom, $urandom});
            send_beat(OP_LD_ICOL, 8'(i), {$urandom, $urandom});
        end
    endtask

    task automatic test_directed();
        set_geometry(4, 1, 1);
        send_beat(OP_ENC, 8'h00, 64'h0);
        send_beat(OP_DEC, 8'hff, '1);
        send_beat(OP_LD_KEY, 8'd33, 64'hdead_beef_0000_0001);
        send_beat(OP_LD_COL, 8'd64, '1);
        send_beat(OP_LD_ICOL, 8'hff, '1);
        send_beat(OP_NONE, 8'h55, 64'h5555_aaaa_5555_aaaa);
        send_beat(OP_ENC, 8'haa, 64'haaaa_5555_aaaa_5555);
        set_geometry(15, 31, 0);          // saturated width, count, rounds
        send_beat(OP_ENC, 8'h0, 64'h0123_4567_89ab_cdef);
        send_beat(OP_DEC, 8'h0, 64'hfedc_ba98_7654_3210);
        set_geometry(0, 0, 63);
        send_beat(OP_ENC, 8'h0, '1);
        send_beat(OP_DEC, 8'h0, 64'h8000_0000_0000_0001);
        set_geometry(7, 10, 2);           // chunk running past bit 63
        send_beat(OP_ENC, 8'h0, '1);
        send_beat(OP_DEC, 8'h0, 64'h0);
        set_geometry(8, 16, 32);
        send_beat(OP_ENC, 8'h0, 64'h1);
        send_beat(OP_DEC, 8'h0, '1);
        send_beat(OP_LD_SBOX, 8'hff, 64'hffff_ffff_ffff_ff3c);
        send_beat(OP_ENC, 8'h0, '1);
    endtask

    task automatic test_random();
        int unsigned op_pick;
        logic [63:0] d;
        for (int phase = 0; phase < 8; phase++) begin
            stall_enable = (phase != 3);
            set_geometry($urandom_range(0, 15), $urandom_range(0, 31),
                         (phase == 0) ? 31 : $urandom_range(0, 6));
            for (int k = 0; k < 16; k++) begin
                op_pick = $urandom_range(0, 9);
                d = {$urandom, $urandom};
                if (op_pick < 4) send_beat(OP_ENC, 8'($urandom), d);
                else if (op_pick < 7) send_beat(OP_DEC, 8'($urandom), d);
                else if (op_pick == 7) send_beat(3'($urandom_range(OP_LD_KEY, OP_LD_ISBOX)),
                                                 8'($urandom), d);
                else if (op_pick == 8) send_beat(3'($urandom_range(OP_LD_COL, OP_LD_ICOL)),
                                                 8'($urandom_range(0, 80)), d);
                else send_beat(OP_NONE, 8'($urandom), d);
            end
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_load_tables();
        test_directed();
        test_random();
        drain();
        repeat (3000) @(posedge i_clk);
        $display("covered %0d cipher blocks and %0d table loads over several geometries",
                 n_blocks, n_loads);
        $display("cycles used: %0d", cycles);
        if (n_errors == 0 && expected_blocks.size() == 0)
            $display("[spn_block_cipher_engine] OK");
        else
            $display("[spn_block_cipher_engine] ERROR");
        $finish;
    end
endmodule

// File: sim.f
sv/spn_pkg.sv
sv/spn_cfg.sv
sv/spn_tables.sv
sv/spn_round.sv
sv/spn_block_cipher_engine.sv
tb/tb_spn_block_cipher_engine.sv
